[src/fbc_pkg.sv]
// Shared types and constants of the frustum box cull core.
package fbc_pkg;

  localparam int BOX_W      = 18;   // box coordinate width
  localparam int ENTRY_W    = 32;   // matrix entry, Q20.12
  localparam int COEF_W     = ENTRY_W + 1;     // plane coefficient, exact sum
  localparam int PROD_W     = COEF_W + BOX_W;  // coefficient times coordinate
  localparam int PSUM_W     = PROD_W + 1;      // sum of two terms
  localparam int SUM_W      = PSUM_W + 1;      // sum of four terms
  localparam int NUM_PLANES = 6;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_W      = 64;
  localparam int S_TDATA_W  = 112;  // six 18-bit fields, padded to bytes
  localparam int M_TDATA_W  = 8;
  localparam int NUM_STAGES = 5;

  // Near plane uses the z column alone (depth range zero to one).
  localparam logic ZERO_TO_ONE_DEPTH = 1'b1;

  // Plane slots
  localparam int PL_LEFT   = 0;
  localparam int PL_RIGHT  = 1;
  localparam int PL_BOTTOM = 2;
  localparam int PL_TOP    = 3;
  localparam int PL_NEAR   = 4;
  localparam int PL_FAR    = 5;

  // Reset gives the identity matrix
  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_0000_0000,
    64'h0000_1000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_1000,
    64'h0000_0000_0000_0000,
    64'h0000_1000_0000_0000
  };

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } plane_coef_t;

  typedef struct packed {
    logic signed [BOX_W-1:0] x;
    logic signed [BOX_W-1:0] y;
    logic signed [BOX_W-1:0] z;
  } corner_t;

  typedef struct packed {
    logic st1;
    logic st2;
    logic st3;
  } lane_load_t;

endpackage

[src/fbc_coef.sv]
// Matrix register file and per-plane coefficient registers.
module fbc_coef
  import fbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output plane_coef_t          coef [NUM_PLANES]
);

  logic [CFG_W-1:0]         mat [NUM_REGS];
  logic signed [COEF_W-1:0] mx  [NUM_ROWS][NUM_ROWS];
  logic signed [COEF_W-1:0] pc  [NUM_PLANES][NUM_ROWS];

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) mat[i] <= CFG_RESET[i];
    end else if (cfg_valid) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  // Sign-extended matrix entries, then column sums and differences per plane
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_ROWS; c++) begin
        mx[r][c] = COEF_W'(signed'(mat[2*r + (c >> 1)][(c & 1)*ENTRY_W +: ENTRY_W]));
      end
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      pc[PL_LEFT][r]   = mx[r][3] + mx[r][0];
      pc[PL_RIGHT][r]  = mx[r][3] - mx[r][0];
      pc[PL_BOTTOM][r] = mx[r][3] + mx[r][1];
      pc[PL_TOP][r]    = mx[r][3] - mx[r][1];
      pc[PL_NEAR][r]   = ZERO_TO_ONE_DEPTH ? mx[r][2] : mx[r][3] + mx[r][2];
      pc[PL_FAR][r]    = mx[r][3] - mx[r][2];
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      coef[p] <= '{a: pc[p][0], b: pc[p][1], c: pc[p][2], d: pc[p][3]};
    end
  end

endmodule

[src/fbc_lane.sv]
// One plane test: corner select and multiply, pairwise add, final add and sign.
module fbc_lane
  import fbc_pkg::*;
(
  input  logic        clk,
  input  plane_coef_t coef,
  input  corner_t     box_min,
  input  corner_t     box_max,
  input  lane_load_t  load,
  output logic        culled
);

  logic signed [BOX_W-1:0]  sel_x, sel_y, sel_z;
  logic signed [PROD_W-1:0] prod_a, prod_b, prod_c;
  logic signed [COEF_W-1:0] d1;
  logic signed [PSUM_W-1:0] psum_ab, psum_cd;
  logic signed [SUM_W-1:0]  sum;

  // Corner furthest along the normal; zero counts as non-negative
  assign sel_x = coef.a[COEF_W-1] ? box_min.x : box_max.x;
  assign sel_y = coef.b[COEF_W-1] ? box_min.y : box_max.y;
  assign sel_z = coef.c[COEF_W-1] ? box_min.z : box_max.z;

  always_ff @(posedge clk) begin
    if (load.st1) begin
      prod_a <= coef.a * sel_x;
      prod_b <= coef.b * sel_y;
      prod_c <= coef.c * sel_z;
      d1     <= coef.d;
    end
  end

  always_ff @(posedge clk) begin
    if (load.st2) begin
      psum_ab <= PSUM_W'(prod_a) + PSUM_W'(prod_b);
      psum_cd <= PSUM_W'(prod_c) + PSUM_W'(d1);
    end
  end

  assign sum = SUM_W'(psum_ab) + SUM_W'(psum_cd);

  always_ff @(posedge clk) begin
    if (load.st3) begin
      culled <= sum[SUM_W-1];
    end
  end

endmodule

[src/frustum_box_cull_core.sv]
// Frustum box cull core: top level with stream ports and pipeline control.
//
// Tests one axis-aligned box per item against the six clip planes of a
// row-vector view-projection matrix held in eight 64-bit registers (Q20.12
// entries, reset to identity) and returns visible = 0 when the box lies
// strictly behind any plane. Arithmetic is exact. The core takes one box
// every clock unless the output stalls, through five register stages:
// input register, six parallel 33x18 multiplier lanes, a pairwise add,
// the final add with sign test, and the output register. Each stage
// only holds when the stage after it is full and stalled, so bubbles
// close up and the input keeps flowing while a result waits. Plane
// coefficients are rebuilt from the matrix registers into a register every
// cycle, so write the matrix only while no box is in flight. Writes are
// taken whenever out of reset.
module frustum_box_cull_core
  import fbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input boxes
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // results
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // visible, pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // matrix register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  plane_coef_t            coef [NUM_PLANES];
  logic [NUM_STAGES-1:0]  vld;
  logic [NUM_STAGES-1:0]  rdy;
  corner_t                box_min, box_max;
  lane_load_t             lane_load;
  logic [NUM_PLANES-1:0]  culled;
  logic                   visible;

  fbc_coef u_coef (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  // Stage k may load when empty or when stage k+1 loads
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0] && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: input register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      box_min <= '{x: s_tdata[0*BOX_W +: BOX_W], y: s_tdata[1*BOX_W +: BOX_W],
                   z: s_tdata[2*BOX_W +: BOX_W]};
      box_max <= '{x: s_tdata[3*BOX_W +: BOX_W], y: s_tdata[4*BOX_W +: BOX_W],
                   z: s_tdata[5*BOX_W +: BOX_W]};
    end
  end

  // Stages 1..3 live in the lanes
  assign lane_load = '{st1: rdy[1], st2: rdy[2], st3: rdy[3]};

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    fbc_lane u_lane (
      .clk     (clk),
      .coef    (coef[p]),
      .box_min (box_min),
      .box_max (box_max),
      .load    (lane_load),
      .culled  (culled[p])
    );
  end

  // Stage 4: output register
  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES-1]) begin
      visible <= ~|culled;
    end
  end

  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, visible};

  // An accepted box occupies the input stage on the next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted box not held in input stage");

  // A box in the last lane stage moves to the output when there is room
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    vld[3] && rdy[3] |=> vld[NUM_STAGES-1])
    else $error("box lost between lane and output stage");

  // Input stalls only when every stage is full (ready is held low in reset)
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !rst && !s_tready |-> (&vld) && !m_tready)
    else $error("input stalled with a free stage");

endmodule

[tb/frustum_box_cull_core_tb.sv]
// Self-checking stream testbench for the frustum box cull core.
`timescale 1ns / 1ps

module frustum_box_cull_core_tb;
  import fbc_pkg::*;

  localparam int COORD_MAX = (1 << (BOX_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (BOX_W - 1));
  localparam int COL_Z = 2;          // z column of the matrix
  localparam int COL_W = 3;          // w column of the matrix
  localparam int VIS_BIT = 0;        // visible flag in m_tdata
  localparam int NUM_DIRECTED = 18;
  localparam int NUM_PHASES = 7;
  localparam int RANDOM_PER_PHASE = 170;
  localparam int TIMEOUT_NS = 2_000_000;
  localparam int MAX_PRINTED = 40;

  // How a table row is checked: typed-in result or predictor
  typedef enum int {
    ROW_CULLED    = 0,
    ROW_VISIBLE   = 1,
    ROW_PREDICTED = 2
  } row_check_e;

  // Matrix loaded for each phase
  typedef enum int {
    MAT_IDENTITY,
    MAT_NEG_ONE,
    MAT_POS_MAX,
    MAT_NEG_MAX,
    MAT_SMALL,
    MAT_RANDOM
  } matrix_kind_e;

  // One box; index 0 is x. Packs straight into s_tdata, min_x lowest.
  typedef struct packed {
    logic [2:0][BOX_W-1:0] hi;
    logic [2:0][BOX_W-1:0] lo;
  } box_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, pad
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // visible, pad
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Testbench copy of the matrix registers
  logic [CFG_W-1:0] matrix_regs [NUM_REGS];
  // Visible flags still owed by the core, oldest first
  bit visible_expected [$];

  int mismatch_count = 0;
  int result_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Directed boxes under the reset identity matrix. With identity the box is
  // visible iff max_x >= -1, min_x <= 1, max_y >= -1, min_y <= 1,
  // max_z >= 0 (near, depth zero to one) and min_z <= 1.
  // Columns: min_x, min_y, min_z, max_x, max_y, max_z, check
  int directed_boxes [NUM_DIRECTED][7] = '{
    '{0, 0, 0, 0, 0, 0, ROW_VISIBLE},
    '{-1, -1, 0, 1, 1, 1, ROW_VISIBLE},
    '{-5, 0, 0, -2, 0, 0, ROW_CULLED},       // behind left
    '{-1, 0, 0, -1, 0, 0, ROW_VISIBLE},      // on left plane, not culled
    '{2, 0, 0, 5, 0, 0, ROW_CULLED},         // behind right
    '{0, -9, 0, 0, -2, 0, ROW_CULLED},       // behind bottom
    '{0, 2, 0, 0, 3, 0, ROW_CULLED},         // behind top
    '{0, 0, -3, 0, 0, -1, ROW_CULLED},       // behind near
    '{0, 0, 2, 0, 0, 4, ROW_CULLED},         // behind far
    '{0, 0, 1, 0, 0, 1, ROW_VISIBLE},        // on far plane
    '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, ROW_VISIBLE},
    '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, ROW_CULLED},
    '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, ROW_CULLED},
    // inverted boxes, taken as given
    '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, ROW_CULLED},
    '{1, 1, 0, -1, -1, 0, ROW_VISIBLE},
    '{1, 1, 1, -1, -1, -1, ROW_CULLED},
    '{-7, 3, -2, 4, 12, 9, ROW_PREDICTED},
    '{-100, -100, -50, 100, 100, 50, ROW_PREDICTED}
  };

  matrix_kind_e phase_matrix [NUM_PHASES] = '{
    MAT_IDENTITY, MAT_NEG_ONE, MAT_POS_MAX, MAT_NEG_MAX,
    MAT_SMALL, MAT_RANDOM, MAT_IDENTITY
  };

  frustum_box_cull_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Six planes from the matrix columns; the box is culled if the corner
  // furthest along any plane normal is strictly behind it. Exact in 64 bits.
  function automatic bit box_is_visible(input box_t b);
    longint                  entry [NUM_ROWS][4];
    logic signed [ENTRY_W-1:0] half;
    logic signed [BOX_W-1:0] lo_c;
    logic signed [BOX_W-1:0] hi_c;
    longint                  coef;
    longint                  coord;
    longint                  sum;
    int                      col;
    bit                      vis;
    vis = 1'b1;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < 4; c++) begin
        half = c[0] ? matrix_regs[r * 2 + c / 2][63:32] : matrix_regs[r * 2 + c / 2][31:0];
        entry[r][c] = half;
      end
    end
    for (int pl = 0; pl < NUM_PLANES; pl++) begin
      col = pl / 2;
      sum = 0;
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (pl == PL_NEAR && ZERO_TO_ONE_DEPTH) begin
          coef = entry[r][COL_Z];
        end else if (pl % 2 == 0) begin
          coef = entry[r][COL_W] + entry[r][col];
        end else begin
          coef = entry[r][COL_W] - entry[r][col];
        end
        if (r == NUM_ROWS - 1) begin
          sum += coef;     // translation row: constant term
        end else begin
          lo_c = b.lo[r];
          hi_c = b.hi[r];
          // zero counts as non-negative, so the max side is taken
          coord = (coef >= 0) ? hi_c : lo_c;
          sum += coef * coord;
        end
      end
      if (sum < 0) vis = 1'b0;
    end
    return vis;
  endfunction

  // Mostly small boxes around the origin, some full-range, some at the rails
  function automatic box_t random_box();
    box_t                    b;
    logic signed [BOX_W-1:0] v [2];
    logic signed [BOX_W-1:0] t;
    int                      pick;
    pick = $urandom_range(99);
    for (int a = 0; a < 3; a++) begin
      for (int e = 0; e < 2; e++) begin
        if (pick < 60) begin
          v[e] = BOX_W'(int'($urandom_range(12)) - 6);
        end else if (pick < 85) begin
          v[e] = BOX_W'($urandom);
        end else begin
          case ($urandom_range(4))
            0: v[e] = BOX_W'(COORD_MIN);
            1: v[e] = BOX_W'(COORD_MAX);
            2: v[e] = BOX_W'(-1);
            3: v[e] = BOX_W'(0);
            default: v[e] = BOX_W'(1);
          endcase
        end
      end
      // keep most boxes well formed, leave some inverted
      if (v[0] > v[1] && $urandom_range(9) != 0) begin
        t = v[0];
        v[0] = v[1];
        v[1] = t;
      end
      b.lo[a] = v[0];
      b.hi[a] = v[1];
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_PRINTED) $display("%0t ns  mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // s_tvalid stays high between back-to-back items; only idles lower it
  task automatic send_box(input box_t b, input row_check_e check);
    bit vis;
    vis = (check == ROW_PREDICTED) ? box_is_visible(b) : (check == ROW_VISIBLE);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - 6 * BOX_W){1'b0}}, b};
    do @(posedge clk); while (!s_tready);
    visible_expected = {visible_expected, vis};
  endtask

  // Wait out every owed result, then let the pipeline empty, before touching
  // the matrix or ending the run
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (visible_expected.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 2) @(posedge clk);
  endtask

  task automatic load_matrix(input matrix_kind_e kind);
    logic [CFG_W-1:0] vals [NUM_REGS];
    for (int r = 0; r < NUM_REGS; r++) begin
      case (kind)
        MAT_IDENTITY: vals[r] = CFG_RESET[r];
        MAT_NEG_ONE:  vals[r] = '1;                        // every entry -1 lsb
        MAT_POS_MAX:  vals[r] = {2{32'h7FFF_FFFF}};
        MAT_NEG_MAX:  vals[r] = {2{32'h8000_0000}};
        MAT_SMALL: begin
          vals[r][63:32] = 32'(int'($urandom_range(65536)) - 32768);
          vals[r][31:0]  = 32'(int'($urandom_range(65536)) - 32768);
        end
        default:      vals[r] = {$urandom, $urandom};
      endcase
    end
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_IDX_W'(r);
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      matrix_regs[r] = vals[r];
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: check each accepted item, then pick next ready at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (visible_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none owed", result_count));
      end else if (m_tdata[VIS_BIT] !== visible_expected[0]) begin
        report_mismatch($sformatf("result %0d visible %b, predicted %b",
                                  result_count, m_tdata[VIS_BIT], visible_expected[0]));
      end
      if (visible_expected.size() != 0) void'(visible_expected.pop_front());
      result_count++;
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    box_t b;
    for (int r = 0; r < NUM_REGS; r++) matrix_regs[r] = CFG_RESET[r];
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // sender idles lightly and receiver heavily, then swapped, then none
      if (ph < 2) begin
        send_idle_pct = 29;
        recv_idle_pct = 75;
      end else if (ph < 4) begin
        send_idle_pct = 75;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (ph == 0) begin
        // reset identity matrix: walk the directed table first
        for (int i = 0; i < NUM_DIRECTED; i++) begin
          for (int a = 0; a < 3; a++) begin
            b.lo[a] = BOX_W'(directed_boxes[i][a]);
            b.hi[a] = BOX_W'(directed_boxes[i][a + 3]);
          end
          send_box(b, row_check_e'(directed_boxes[i][6]));
        end
      end else begin
        drain_results();
        load_matrix(phase_matrix[ph]);
      end

      repeat (RANDOM_PER_PHASE) send_box(random_box(), ROW_PREDICTED);
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
